>>> src/assert_macros.svh
// Assertion helpers used by the compressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lzwdh_pkg.sv
`timescale 1ns / 1ps
package lzwdh_pkg;
  // Default dictionary depth.
  localparam int TABLE_SIZE_DEF = 4096;
  // Single-byte root codes occupying the low slots.
  localparam int ROOT_COUNT = 256;
  // Code width at the start of a dictionary.
  localparam int START_WIDTH = 8;
  // Multiplier of the extension byte in the step hash.
  localparam int EXT_MUL = 7;
endpackage

>>> src/lzwdh_ram.sv
`timescale 1ns / 1ps
module lzwdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/lzw_compressor_double_hash.sv
`timescale 1ns / 1ps
// LZW compressor, one input byte per beat, variable-width codes (8 bits up to
// log2(TABLE_SIZE)) packed MSB first into output bytes. The dictionary lives in
// one RAM with a registered read port, searched by double hashing; each probe
// sets the address in S_PROBE, then reads the registered port and compares in
// S_CHECK. A byte is accepted in S_IDLE, probed until a hit, a free slot or the
// last probe, and closed in S_TAIL; the first byte of a stream skips the probes.
// A miss adds a pack step, a drain of each whole output byte (held while out_stall
// holds) and an insert of the new entry. The last byte of a stream then packs the
// final code and drains every output byte including the padded one before it
// wraps up. The RAM is swept clear, entry by entry, after reset, after each end
// of stream and when the dictionary fills (a fill then restarts the slot search
// and probes again); no beat is accepted during the sweep. in_stall is high
// whenever a byte is in work.
`include "assert_macros.svh"
module lzw_compressor_double_hash
  import lzwdh_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  localparam int AW   = $clog2(TABLE_SIZE);
  localparam int CW   = $clog2(AW + 1);
  localparam int ACCW = AW + 7;
  localparam int NW   = $clog2(AW + 8);
  localparam int EW   = 1 + AW + 8 + AW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_SEARCH = 4'd2;
  localparam logic [3:0] S_PROBE  = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_PACK   = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_INSERT = 4'd7;
  localparam logic [3:0] S_TAIL   = 4'd8;

  logic [3:0]      state_r, state_nxt, ret_r, ret_nxt;
  logic [AW-1:0]   slot_r, slot_nxt, step_r, step_nxt, probe_r, probe_nxt;
  logic [AW-1:0]   clr_r, clr_nxt, prefix_r, prefix_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt, have_r, have_nxt;
  logic            ins_r, ins_nxt, fin_r, fin_nxt;
  logic [ACCW-1:0] acc_r, acc_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic [CW-1:0]   width_r, width_nxt;
  logic            ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [7:0]      obyte_r, obyte_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [EW-1:0]   wdata, rdata;

  // Entry word: {valid, prefix, ext, code}
  logic            rd_valid;
  logic [AW-1:0]   rd_prefix, rd_code;
  logic [7:0]      rd_ext;
  assign rd_valid  = rdata[EW-1];
  assign rd_prefix = rdata[EW-2 -: AW];
  assign rd_ext    = rdata[AW+7:AW];
  assign rd_code   = rdata[AW-1:0];

  lzwdh_ram #(.WIDTH(EW), .DEPTH(TABLE_SIZE)) u_dict (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(slot_r),
    .rdata(rdata)
  );

  // Hashes of (prefix, byte); byte comes from the port while idle.
  logic [7:0]     hbyte;
  logic [AW+7:0]  h1_full;
  logic [AW+10:0] h2_full;
  logic [AW-1:0]  h1, h2;
  assign hbyte   = (state_r == S_IDLE) ? in_byte : byte_r;
  assign h1_full = {prefix_r, 8'd0} ^ (AW + 8)'(hbyte);
  assign h2_full = (AW + 11)'({prefix_r, 5'd0}) ^ (AW + 11)'(11'(hbyte) * 11'(EXT_MUL));
  assign h1      = h1_full[AW-1:0];
  assign h2      = h2_full[AW-1:0] | AW'(1);

  // Probe result
  logic is_root, slot_used, hit;
  assign is_root   = (slot_r[AW-1:8] == '0);
  assign slot_used = is_root || rd_valid;
  assign hit       = !is_root && rd_valid && (rd_prefix == prefix_r) && (rd_ext == byte_r);

  // Code packing and byte extraction
  logic [AW:0]     wmask_full;
  logic [AW-1:0]   code_mask;
  logic [ACCW-1:0] acc_shift, drain_word;
  logic [7:0]      pad_byte;
  logic            out_free, grow;
  assign wmask_full = ((AW + 1)'(1) << width_r) - (AW + 1)'(1);
  assign code_mask  = prefix_r & wmask_full[AW-1:0];
  assign acc_shift  = (acc_r << width_r) | ACCW'(code_mask);
  assign drain_word = acc_r >> (n_r - NW'(8));
  assign pad_byte   = acc_r[7:0] << (4'd8 - 4'(n_r));
  assign out_free   = !ovalid_r || !out_stall;
  assign grow       = (count_r >> width_r) != '0;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    slot_nxt   = slot_r;
    step_nxt   = step_r;
    probe_nxt  = probe_r;
    clr_nxt    = clr_r;
    prefix_nxt = prefix_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    have_nxt   = have_r;
    ins_nxt    = ins_r;
    fin_nxt    = fin_r;
    acc_nxt    = acc_r;
    n_nxt      = n_r;
    count_nxt  = count_r;
    width_nxt  = width_r;
    ovalid_nxt = ovalid_r && out_stall;
    olast_nxt  = olast_r;
    obyte_nxt  = obyte_r;
    we         = 1'b0;
    waddr      = clr_r;
    wdata      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_byte;
          last_nxt = in_last_byte;
          if (!have_r) begin
            prefix_nxt = AW'(in_byte);
            have_nxt   = 1'b1;
            state_nxt  = S_TAIL;
          end else begin
            slot_nxt  = h1;
            step_nxt  = h2;
            probe_nxt = '0;
            ins_nxt   = 1'b0;
            state_nxt = S_PROBE;
          end
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = ret_r;
        end
      end
      S_SEARCH: begin
        slot_nxt  = h1;
        step_nxt  = h2;
        probe_nxt = '0;
        ins_nxt   = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!ins_r && hit) begin
          prefix_nxt = rd_code;
          state_nxt  = S_TAIL;
        end else if (!slot_used || &probe_r) begin
          // miss: slot_r is the free slot (or table exhausted)
          fin_nxt   = 1'b0;
          state_nxt = ins_r ? S_INSERT : S_PACK;
        end else begin
          slot_nxt  = slot_r + step_r;
          probe_nxt = probe_r + AW'(1);
          state_nxt = S_PROBE;
        end
      end
      S_PACK: begin
        acc_nxt   = acc_shift;
        n_nxt     = n_r + NW'(width_r);
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (n_r >= NW'(8)) begin
          if (out_free) begin
            ovalid_nxt = 1'b1;
            obyte_nxt  = drain_word[7:0];
            olast_nxt  = fin_r && (n_r == NW'(8));
            n_nxt      = n_r - NW'(8);
          end
        end else if (!fin_r) begin
          state_nxt = S_INSERT;
        end else if (n_r != '0) begin
          if (out_free) begin
            ovalid_nxt = 1'b1;
            obyte_nxt  = pad_byte;
            olast_nxt  = 1'b1;
            n_nxt      = '0;
          end
        end else begin
          // end of stream: back to the reset state
          have_nxt   = 1'b0;
          prefix_nxt = '0;
          fin_nxt    = 1'b0;
          count_nxt  = (AW + 1)'(ROOT_COUNT);
          width_nxt  = CW'(START_WIDTH);
          clr_nxt    = '0;
          ret_nxt    = S_IDLE;
          state_nxt  = S_CLEAR;
        end
      end
      S_INSERT: begin
        if (count_r[AW]) begin
          // dictionary full: restart it, then find a slot again
          count_nxt = (AW + 1)'(ROOT_COUNT);
          width_nxt = CW'(START_WIDTH);
          clr_nxt   = '0;
          ret_nxt   = S_SEARCH;
          state_nxt = S_CLEAR;
        end else begin
          we         = 1'b1;
          waddr      = slot_r;
          wdata      = {1'b1, prefix_r, byte_r, count_r[AW-1:0]};
          width_nxt  = grow ? width_r + CW'(1) : width_r;
          count_nxt  = count_r + (AW + 1)'(1);
          prefix_nxt = AW'(byte_r);
          ins_nxt    = 1'b0;
          state_nxt  = S_TAIL;
        end
      end
      S_TAIL: begin
        if (last_r) begin
          fin_nxt   = 1'b1;
          state_nxt = S_PACK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ret_r    <= S_IDLE;
      clr_r    <= '0;
      have_r   <= 1'b0;
      prefix_r <= '0;
      ins_r    <= 1'b0;
      fin_r    <= 1'b0;
      n_r      <= '0;
      count_r  <= (AW + 1)'(ROOT_COUNT);
      width_r  <= CW'(START_WIDTH);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      clr_r    <= clr_nxt;
      have_r   <= have_nxt;
      prefix_r <= prefix_nxt;
      ins_r    <= ins_nxt;
      fin_r    <= fin_nxt;
      n_r      <= n_nxt;
      count_r  <= count_nxt;
      width_r  <= width_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    step_r  <= step_nxt;
    probe_r <= probe_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    acc_r   <= acc_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

  `AST_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE, "accepted beat did not start work")
  `AST_ALWAYS(a_count_range, count_r >= (AW + 1)'(ROOT_COUNT) && count_r <= (AW + 1)'(TABLE_SIZE), "entry count out of range")
  `AST_ALWAYS(a_width_range, width_r >= CW'(START_WIDTH) && width_r <= CW'(AW), "code width out of range")
  `AST_NEXT(a_out_hold, ovalid_r && out_stall, ovalid_r && $stable(obyte_r), "stalled output beat lost")
endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import lzwdh_pkg::*;

  localparam int TS          = TABLE_SIZE_DEF;
  localparam int STALL_LIMIT = 20000;   // covers the RAM sweep after each stream
  localparam int QUIET_TAIL  = 40;      // last beats sent with no idling

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    logic       drain_first;  // hold off until every expected byte is out
  } byte_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } packed_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;

  lzw_compressor_double_hash u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Dictionary mirror and packer state
  logic [15:0]  dict_prefix [TS];
  logic [7:0]   dict_ext    [TS];
  logic [11:0]  dict_code   [TS];
  logic         dict_used   [TS];
  int unsigned  n_entries;
  int unsigned  width;
  int unsigned  cur_prefix;
  bit           prefix_set;
  logic [63:0]  bit_acc;
  int unsigned  bit_cnt;

  byte_beat_t   byte_queue[$];
  packed_beat_t packed_expected[$];
  int           errors;
  int           bytes_sent;
  int           bytes_total;
  int           packed_seen;
  int           streams_done;
  int           max_width_seen;
  bit           stim_done;

  function automatic void dict_clear();
    for (int i = 0; i < TS; i++) dict_used[i] = 1'b0;
    for (int i = 0; i < ROOT_COUNT; i++) begin
      dict_prefix[i] = 16'hFFFF;
      dict_ext[i]    = i[7:0];
      dict_code[i]   = i[11:0];
      dict_used[i]   = 1'b1;
    end
    n_entries = ROOT_COUNT;
    width     = START_WIDTH;
  endfunction

  function automatic void compressor_reset();
    dict_clear();
    cur_prefix  = 0;
    prefix_set  = 1'b0;
    bit_acc     = '0;
    bit_cnt     = 0;
  endfunction

  function automatic int unsigned slot_at(int unsigned p, int unsigned e, int unsigned i);
    int unsigned h1;
    int unsigned h2;
    h1 = ((p << 8) ^ e) & (TS - 1);
    h2 = (((p << 5) ^ (e * EXT_MUL)) & (TS - 1)) | 1;
    return (h1 + i * h2) & (TS - 1);
  endfunction

  function automatic bit dict_find(int unsigned p, int unsigned e, output int unsigned code);
    int unsigned s;
    code = 0;
    for (int unsigned i = 0; i < TS; i++) begin
      s = slot_at(p, e, i);
      if (!dict_used[s]) return 1'b0;
      if (dict_prefix[s] == p[15:0] && dict_ext[s] == e[7:0]) begin
        code = 32'(dict_code[s]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void dict_add(int unsigned p, int unsigned e);
    int unsigned s;
    if (n_entries >= TS) dict_clear();
    if (n_entries >= (1 << width)) width++;
    if (width > max_width_seen) max_width_seen = width;
    for (int unsigned i = 0; i < TS; i++) begin
      s = slot_at(p, e, i);
      if (!dict_used[s]) begin
        dict_prefix[s] = p[15:0];
        dict_ext[s]    = e[7:0];
        dict_code[s]   = n_entries[11:0];
        dict_used[s]   = 1'b1;
        n_entries++;
        return;
      end
    end
  endfunction

  // Append a code at the current width and queue every whole byte
  function automatic void emit_code(int unsigned code);
    packed_beat_t pb;
    bit_acc = (bit_acc << width) | (code & ((1 << width) - 1));
    bit_cnt += width;
    while (bit_cnt >= 8) begin
      pb.data    = 8'(bit_acc >> (bit_cnt - 8));
      pb.is_last = 1'b0;
      packed_expected.push_back(pb);
      bit_cnt -= 8;
      bit_acc &= (64'd1 << bit_cnt) - 1;
    end
  endfunction

  // Expected packed output for one accepted input byte
  function automatic void compress_byte(byte_beat_t bt);
    int unsigned  code;
    packed_beat_t pb;
    if (!prefix_set) begin
      cur_prefix = 32'(bt.data);
      prefix_set = 1'b1;
    end else if (dict_find(cur_prefix, 32'(bt.data), code)) begin
      cur_prefix = code;
    end else begin
      emit_code(cur_prefix);
      dict_add(cur_prefix, 32'(bt.data));
      cur_prefix = 32'(bt.data);
    end
    if (bt.is_last) begin
      emit_code(cur_prefix);
      if (bit_cnt > 0) begin
        pb.data    = 8'(bit_acc << (8 - bit_cnt));
        pb.is_last = 1'b0;
        packed_expected.push_back(pb);
      end
      packed_expected[packed_expected.size() - 1].is_last = 1'b1;
      streams_done++;
      compressor_reset();
    end
  endfunction

  task automatic add_stream(int len, int lo, int hi, bit drain);
    byte_beat_t bt;
    for (int i = 0; i < len; i++) begin
      bt.data        = 8'($urandom_range(hi, lo));
      bt.is_last     = (i == len - 1);
      bt.drain_first = drain && (i == 0);
      byte_queue.push_back(bt);
    end
  endtask

  task automatic add_bytes(byte_beat_t bl[$]);
    foreach (bl[i]) byte_queue.push_back(bl[i]);
  endtask

  // Stimulus
  initial begin
    byte_beat_t bl[$];
    byte_beat_t bt;
    int base;
    errors = 0; bytes_sent = 0; packed_seen = 0; streams_done = 0;
    max_width_seen = START_WIDTH; stim_done = 1'b0;
    compressor_reset();

    // single-byte streams at both extremes
    bt = '{8'h00, 1'b1, 1'b0}; byte_queue.push_back(bt);
    bt = '{8'hFF, 1'b1, 1'b0}; byte_queue.push_back(bt);
    // repeated byte: chain of hits
    add_stream(8, 8'h41, 8'h41, 1'b0);
    // alternating pair
    for (int i = 0; i < 8; i++) begin
      bt = '{(i % 2) ? 8'h42 : 8'h41, i == 7, 1'b0};
      bl.push_back(bt);
    end
    add_bytes(bl);
    bl.delete();
    // every bit both ways
    bl.push_back('{8'h00, 1'b0, 1'b0});
    bl.push_back('{8'hFF, 1'b0, 1'b0});
    bl.push_back('{8'h80, 1'b0, 1'b0});
    bl.push_back('{8'h7F, 1'b0, 1'b0});
    bl.push_back('{8'h55, 1'b0, 1'b0});
    bl.push_back('{8'hAA, 1'b1, 1'b0});
    add_bytes(bl);

    // long stream of mostly misses to push the code width to 9
    add_stream(270, 0, 255, 1'b1);
    // short streams over small alphabets for hits
    while (byte_queue.size() < 310) begin
      base = $urandom_range(252, 0);
      add_stream($urandom_range(12, 1), base, base + $urandom_range(3, 0), 1'b0);
    end
    bytes_total = byte_queue.size();
    stim_done = 1'b1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver
  int in_gap;
  always @(posedge clk) begin
    bit         next_valid;
    byte_beat_t bt;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_byte      <= 8'h00;
      in_last_byte <= 1'b0;
      in_gap       = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        compress_byte('{in_byte, in_last_byte, 1'b0});
        bytes_sent++;
        next_valid = 1'b0;
        if (bytes_sent < bytes_total - QUIET_TAIL && $urandom_range(3, 0) == 0)
          in_gap = $urandom_range(5, 1);
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_done && byte_queue.size() > 0 &&
                     !(byte_queue[0].drain_first && packed_expected.size() > 0)) begin
          bt = byte_queue.pop_front();
          in_byte      <= bt.data;
          in_last_byte <= bt.is_last;
          next_valid   = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor and output backpressure
  int out_gap;
  always @(posedge clk) begin
    packed_beat_t pb;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        packed_seen++;
        if (packed_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last);
        end else begin
          pb = packed_expected.pop_front();
          if (out_byte !== pb.data) begin
            errors++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, pb.data, out_byte);
          end
          if (out_last !== pb.is_last) begin
            errors++;
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, pb.is_last, out_last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        if (bytes_sent < bytes_total - QUIET_TAIL && $urandom_range(4, 0) == 0)
          out_gap = $urandom_range(5, 1) - 1;
        out_stall <= (out_gap > 0) || (bytes_sent < bytes_total - QUIET_TAIL &&
                                       out_gap == 0 && $urandom_range(9, 0) == 0);
      end
    end
  end

  // Watchdog: cycles with no accepted beat on either side
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d bytes still expected", packed_expected.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (rst_n && byte_queue.size() == 0 && !in_valid && packed_expected.size() == 0);
    repeat (100) @(posedge clk);
    errors += packed_expected.size();
    $display("compressed %0d input bytes in %0d streams into %0d packed bytes",
             bytes_sent, streams_done, packed_seen);
    $display("widest code seen: %0d bits; %0d errors", max_width_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
